### rtl/asq_pkg.sv
package asq_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam logic [7:0] CHR_A     = 8'h41;
    localparam logic [7:0] CHR_C     = 8'h43;
    localparam logic [7:0] CHR_G     = 8'h47;
    localparam logic [7:0] CHR_T     = 8'h54;
    localparam logic [7:0] CHR_U     = 8'h55;
    localparam logic [7:0] CHR_Z     = 8'h5A;
    localparam logic [7:0] CHR_LO_A  = 8'h61;
    localparam logic [7:0] CHR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHR_DASH  = 8'h2D;
    localparam logic [7:0] CHR_DOT   = 8'h2E;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TILDE = 8'h7E;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_byte_word;

    typedef struct packed {
        logic       printable;
        logic       letter;
        logic       ambig;
        logic       dash;
        logic       dot;
        logic       last;
        logic [7:0] base;
    } t_dec_word;

    function automatic t_dec_word decode(t_byte_word w);
        t_dec_word  d;
        logic [7:0] c;
        c = w.byte_in;
        if (c >= CHR_LO_A && c <= CHR_LO_Z) begin
            c = c - CASE_GAP;
        end
        if (c == CHR_U) begin
            c = CHR_T;
        end
        d.printable = (w.byte_in >= CHR_SPACE) && (w.byte_in <= CHR_TILDE);
        d.letter    = (c >= CHR_A) && (c <= CHR_Z);
        d.ambig     = d.letter && (c != CHR_A) && (c != CHR_C) && (c != CHR_G)
                      && (c != CHR_T);
        d.dash      = (c == CHR_DASH);
        d.dot       = (c == CHR_DOT);
        d.last      = w.last_byte;
        d.base      = c;
        return d;
    endfunction

endpackage

### rtl/asq_if.sv
interface asq_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface asq_stat_if #(
    parameter int W = 16
);
    logic         valid;
    logic         ready;
    logic [W-1:0] base_count;
    logic [W-1:0] align_length;
    logic [W-1:0] ambiguous_count;
    logic [W-1:0] longest_run;
    logic [W-1:0] start_position;
    logic [W-1:0] end_position;

    modport source (
        output valid, output base_count, output align_length, output ambiguous_count,
        output longest_run, output start_position, output end_position, input ready
    );
    modport sink (
        input valid, input base_count, input align_length, input ambiguous_count,
        input longest_run, input start_position, input end_position, output ready
    );
endinterface

### rtl/asq_in_stage.sv
module asq_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  asq_pkg::t_byte_word  i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output asq_pkg::t_dec_word   o_word
);
    import asq_pkg::*;

    logic      r_valid;
    t_dec_word r_word;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= decode(i_word);
        end
    end

endmodule

### rtl/asq_core.sv
module asq_core #(
    parameter int COUNT_BITS = asq_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  asq_pkg::t_dec_word    i_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COUNT_BITS-1:0] o_base_count,
    output logic [COUNT_BITS-1:0] o_align_length,
    output logic [COUNT_BITS-1:0] o_ambiguous_count,
    output logic [COUNT_BITS-1:0] o_longest_run,
    output logic [COUNT_BITS-1:0] o_start_position,
    output logic [COUNT_BITS-1:0] o_end_position
);
    import asq_pkg::*;

    localparam int CW = COUNT_BITS;
    localparam logic [CW-1:0] CountMax = '1;
    localparam logic [CW-1:0] CountOne = CW'(1);

    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_letters, n_letters;
    logic [CW-1:0] r_ambig, n_ambig;
    logic [CW-1:0] r_run, n_run;
    logic [CW-1:0] r_best, n_best;
    logic [7:0]    r_prev, n_prev;
    logic          r_ldm, n_ldm;
    logic          r_inlead, n_inlead;
    logic [CW-1:0] r_first, n_first;
    logic [CW-1:0] r_lastnd, n_lastnd;
    logic [CW-1:0] r_cbdr, n_cbdr;
    logic          r_lwd, n_lwd;

    logic          r_out_valid;
    logic [CW-1:0] r_base_count, r_align_length, r_ambiguous_count;
    logic [CW-1:0] r_longest_run, r_start_position, r_end_position;

    logic [CW-1:0] col, run, res_start, res_end;
    logic          ldm, mark;
    logic          take;

    assign o_ready = !i_word.last || !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_col    = r_col;
        n_letters = r_letters;
        n_ambig  = r_ambig;
        n_run    = r_run;
        n_best   = r_best;
        n_prev   = r_prev;
        n_ldm    = r_ldm;
        n_inlead = r_inlead;
        n_first  = r_first;
        n_lastnd = r_lastnd;
        n_cbdr   = r_cbdr;
        n_lwd    = r_lwd;
        col      = (r_col == CountMax) ? r_col : r_col + CountOne;
        run      = (r_run == CountMax) ? r_run : r_run + CountOne;
        ldm      = r_ldm || ((r_col == '0) && i_word.dash);
        mark     = 1'b0;
        if (i_word.printable) begin
            n_col = col;
            n_ldm = ldm;
            if (i_word.letter) begin
                n_letters = (r_letters == CountMax) ? r_letters : r_letters + CountOne;
                if (i_word.ambig) begin
                    n_ambig = (r_ambig == CountMax) ? r_ambig : r_ambig + CountOne;
                end
                n_run = (r_prev == i_word.base) ? run : CountOne;
                if (n_run > r_best) begin
                    n_best = n_run;
                end
                n_prev = i_word.base;
            end
            if (i_word.dash && ldm) begin
                if (!r_inlead) begin
                    if (!r_lwd) begin
                        n_cbdr = r_lastnd;
                    end
                    mark = 1'b1;
                end
                n_lwd = 1'b1;
            end else begin
                n_inlead = 1'b0;
                n_lwd    = 1'b0;
                mark     = !i_word.dot;
            end
            if (mark) begin
                if (r_first == '0) begin
                    n_first = col;
                end
                n_lastnd = col;
            end
        end
        res_start = n_first;
        res_end   = n_lastnd;
        if (n_ldm && n_lwd) begin
            res_end = n_cbdr;
            if (n_cbdr == '0) begin
                res_start = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (take && i_word.last)) begin
            r_col    <= '0;
            r_letters <= '0;
            r_ambig  <= '0;
            r_run    <= '0;
            r_best   <= CountOne;
            r_prev   <= '0;
            r_ldm    <= 1'b0;
            r_inlead <= 1'b1;
            r_first  <= '0;
            r_lastnd <= '0;
            r_cbdr   <= '0;
            r_lwd    <= 1'b0;
        end else if (take) begin
            r_col    <= n_col;
            r_letters <= n_letters;
            r_ambig  <= n_ambig;
            r_run    <= n_run;
            r_best   <= n_best;
            r_prev   <= n_prev;
            r_ldm    <= n_ldm;
            r_inlead <= n_inlead;
            r_first  <= n_first;
            r_lastnd <= n_lastnd;
            r_cbdr   <= n_cbdr;
            r_lwd    <= n_lwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && i_word.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_word.last) begin
            r_base_count      <= n_letters;
            r_align_length    <= n_col;
            r_ambiguous_count <= n_ambig;
            r_longest_run     <= n_best;
            r_start_position  <= res_start;
            r_end_position    <= res_end;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_base_count      = r_base_count;
    assign o_align_length    = r_align_length;
    assign o_ambiguous_count = r_ambiguous_count;
    assign o_longest_run     = r_longest_run;
    assign o_start_position  = r_start_position;
    assign o_end_position    = r_end_position;

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_longest_run != '0))
        else $error("longest run is zero");

    a_counts_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_ambiguous_count <= r_base_count)
                         && (r_base_count <= r_align_length)))
        else $error("counts out of order");

    a_pos_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (((r_start_position == '0) == (r_end_position == '0))
                         && (r_start_position <= r_end_position)))
        else $error("start and end positions inconsistent");

    a_record_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_word.last) |=> ((r_col == '0) && r_out_valid && r_inlead))
        else $error("record state not cleared after last word");

endmodule

### rtl/aligned_sequence_statistics.sv
// Aligned sequence statistics: takes one raw byte of an aligned record per word, with
// last_byte on the final byte, and returns one summary word per record (base count,
// alignment length, ambiguous count, longest homopolymer run, start and end positions).
// A byte is accepted every cycle unless intake is stalled; after the last byte is
// accepted, it passes through the decode register, and the counter update then loads
// the result register. The counter update sets the rate of one byte per cycle. An
// unread result stalls intake only when the next last byte arrives. Counters are
// COUNT_BITS wide and saturate at their maximum.
module aligned_sequence_statistics #(
    parameter int COUNT_BITS = asq_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    asq_byte_if.sink    i_byte,
    asq_stat_if.source  o_stat
);
    import asq_pkg::*;

    t_byte_word in_word;
    t_dec_word  dec_word;
    logic       dec_valid;
    logic       dec_ready;

    assign in_word.byte_in   = i_byte.byte_in;
    assign in_word.last_byte = i_byte.last_byte;

    asq_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_byte.valid),
        .o_ready (i_byte.ready),
        .i_word  (in_word),
        .o_valid (dec_valid),
        .i_ready (dec_ready),
        .o_word  (dec_word)
    );

    asq_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (dec_valid),
        .o_ready           (dec_ready),
        .i_word            (dec_word),
        .o_valid           (o_stat.valid),
        .i_ready           (o_stat.ready),
        .o_base_count      (o_stat.base_count),
        .o_align_length    (o_stat.align_length),
        .o_ambiguous_count (o_stat.ambiguous_count),
        .o_longest_run     (o_stat.longest_run),
        .o_start_position  (o_stat.start_position),
        .o_end_position    (o_stat.end_position)
    );

endmodule
